[src/hrlv_pkg.sv]
// Shared types, character codes and match tables for the HTTP request line validator.
`timescale 1ns / 1ps
`default_nettype none

package hrlv_pkg;

    // Largest request, in bytes, that still earns a verdict other than too large.
    localparam int unsigned MAX_REQUEST_BYTES = 16777216;

    // The byte counter saturates one above the limit, so it must hold MAX_REQUEST_BYTES + 1.
    localparam int unsigned COUNT_WIDTH = $clog2(MAX_REQUEST_BYTES + 2);

    typedef logic [COUNT_WIDTH-1:0] count_t;

    localparam count_t MAX_COUNT = count_t'(MAX_REQUEST_BYTES);
    localparam count_t BYTE_CAP  = count_t'(MAX_REQUEST_BYTES + 1);

    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_SPACE = 8'd32;

    localparam logic [2:0] METHOD_GET_LEN = 3'd3;
    localparam logic [2:0] METHOD_CAP     = 3'd4;
    localparam logic [3:0] VERSION_LEN    = 4'd8;
    localparam logic [3:0] VERSION_CAP    = 4'd9;

    typedef enum logic [1:0] {
        VERDICT_OK          = 2'd0,
        VERDICT_BAD_REQUEST = 2'd1,
        VERDICT_NOT_ALLOWED = 2'd2,
        VERDICT_TOO_LARGE   = 2'd3
    } verdict_t;

    // Progress through the request line.
    typedef struct packed {
        logic [1:0] spaces_seen;
        logic [2:0] method_length;
        logic       method_is_get;
        logic [3:0] version_length;
        logic       version_matches;
    } line_state_t;

    localparam line_state_t LINE_RESET = '{
        spaces_seen:     2'd0,
        method_length:   3'd0,
        method_is_get:   1'b1,
        version_length:  4'd0,
        version_matches: 1'b1
    };

    // Characters of "GET"; the fourth entry is never matched.
    function automatic logic [7:0] get_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h47;
            2'd1:    ch = 8'h45;
            2'd2:    ch = 8'h54;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Characters of "HTTP/1.1".
    function automatic logic [7:0] version_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h48;
            3'd1:    ch = 8'h54;
            3'd2:    ch = 8'h54;
            3'd3:    ch = 8'h50;
            3'd4:    ch = 8'h2F;
            3'd5:    ch = 8'h31;
            3'd6:    ch = 8'h2E;
            default: ch = 8'h31;
        endcase
        return ch;
    endfunction

    // Folds one byte of request line content into the line state.
    function automatic line_state_t line_content(input line_state_t s, input logic [7:0] c);
        line_state_t n;
        n = s;
        case (s.spaces_seen)
            2'd0:
            begin
                if (c == CHAR_SPACE)
                begin
                    n.spaces_seen = 2'd1;
                end
                else
                begin
                    if (s.method_length >= METHOD_GET_LEN || c != get_char(s.method_length[1:0]))
                        n.method_is_get = 1'b0;
                    if (s.method_length < METHOD_CAP)
                        n.method_length = s.method_length + 3'd1;
                end
            end
            2'd1:
            begin
                if (c == CHAR_SPACE)
                    n.spaces_seen = 2'd2;
            end
            default:
            begin
                if (s.version_length >= VERSION_LEN
                    || c != version_char(s.version_length[2:0]))
                    n.version_matches = 1'b0;
                if (s.version_length < VERSION_CAP)
                    n.version_length = s.version_length + 4'd1;
            end
        endcase
        return n;
    endfunction

    // Outcome of a complete request line.
    function automatic verdict_t line_close(input line_state_t s);
        verdict_t v;
        if (s.spaces_seen < 2'd2 || s.method_length == 3'd0 || !s.version_matches
            || s.version_length != VERSION_LEN)
            v = VERDICT_BAD_REQUEST;
        else if (s.method_length != METHOD_GET_LEN || !s.method_is_get)
            v = VERDICT_NOT_ALLOWED;
        else
            v = VERDICT_OK;
        return v;
    endfunction

endpackage

`default_nettype wire

[src/http_request_line_validator.sv]
// Top level of the HTTP request line validator: byte register, scanner state and verdict register.
`timescale 1ns / 1ps
`default_nettype none

// The validator takes an HTTP request one byte per request transfer on the
// data_byte / last_byte channel and, once the byte flagged by last_byte has been
// processed, offers exactly one verdict: too large if the request exceeds
// MAX_REQUEST_BYTES, bad request if the request line is malformed, its version is
// not exactly HTTP/1.1 or no CR LF CR LF follows the line's CR LF, method not
// allowed if the method is not GET, and ok otherwise. Bytes pass through an input
// register and are folded into the scanner state one per cycle, so the block sustains
// one byte per clock outside stalls, with no gaps between requests; a verdict is offered
// from the verdict register once its last byte is processed. The verdict register lets
// scanning carry on while a verdict waits, and only a second final byte arriving while
// the previous verdict is still stalled holds the input back. The critical path is the
// double step of the line scanner after a bare CR followed by another content byte.
module http_request_line_validator (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    input  wire logic       req_valid,
    output logic            req_stall,
    output logic [1:0]      verdict,
    output logic            verdict_valid,
    input  wire logic       verdict_stall
);

    // Input register.
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    // Scanner state.
    logic                 in_header_reg,   in_header_next;
    logic                 cr_pending_reg,  cr_pending_next;
    hrlv_pkg::line_state_t line_reg,       line_next;
    hrlv_pkg::verdict_t   outcome_reg,     outcome_next;
    logic [1:0]           term_prog_reg,   term_prog_next;
    logic                 term_found_reg,  term_found_next;
    hrlv_pkg::count_t     count_reg,       count_next;

    // Output register.
    logic                 verdict_valid_reg;
    hrlv_pkg::verdict_t   verdict_reg,     verdict_next;

    hrlv_pkg::line_state_t line_after_cr;
    logic                  can_process;
    logic                  advance;
    logic [7:0]            term_expect;

    // A byte that yields no verdict can always be processed; a final byte needs
    // the verdict register to be free or emptying this cycle.
    assign can_process = !last_reg || !verdict_valid_reg || !verdict_stall;
    assign advance     = in_valid_reg && can_process;
    assign req_stall   = in_valid_reg && !can_process;

    assign term_expect = term_prog_reg[0] ? hrlv_pkg::CHAR_LF : hrlv_pkg::CHAR_CR;

    always_comb
    begin
        in_header_next  = in_header_reg;
        cr_pending_next = cr_pending_reg;
        line_next       = line_reg;
        outcome_next    = outcome_reg;
        term_prog_next  = term_prog_reg;
        term_found_next = term_found_reg;
        count_next      = count_reg;
        line_after_cr   = hrlv_pkg::line_content(line_reg, hrlv_pkg::CHAR_CR);

        if (count_reg < hrlv_pkg::BYTE_CAP)
            count_next = count_reg + hrlv_pkg::count_t'(1);

        if (!in_header_reg)
        begin
            if (cr_pending_reg)
            begin
                cr_pending_next = 1'b0;
                if (byte_reg == hrlv_pkg::CHAR_LF)
                begin
                    outcome_next   = hrlv_pkg::line_close(line_reg);
                    in_header_next = 1'b1;
                end
                else if (byte_reg == hrlv_pkg::CHAR_CR)
                begin
                    // The earlier CR was bare: it becomes line content.
                    line_next       = line_after_cr;
                    cr_pending_next = 1'b1;
                end
                else
                begin
                    line_next = hrlv_pkg::line_content(line_after_cr, byte_reg);
                end
            end
            else if (byte_reg == hrlv_pkg::CHAR_CR)
            begin
                cr_pending_next = 1'b1;
            end
            else
            begin
                line_next = hrlv_pkg::line_content(line_reg, byte_reg);
            end
        end
        else if (!term_found_reg)
        begin
            if (byte_reg == term_expect)
            begin
                if (term_prog_reg == 2'd3)
                begin
                    term_found_next = 1'b1;
                    term_prog_next  = 2'd0;
                end
                else
                begin
                    term_prog_next = term_prog_reg + 2'd1;
                end
            end
            else
            begin
                term_prog_next = (byte_reg == hrlv_pkg::CHAR_CR) ? 2'd1 : 2'd0;
            end
        end

        if (count_next > hrlv_pkg::MAX_COUNT)
            verdict_next = hrlv_pkg::VERDICT_TOO_LARGE;
        else if (!in_header_next)
            verdict_next = hrlv_pkg::VERDICT_BAD_REQUEST;
        else if (outcome_next != hrlv_pkg::VERDICT_OK)
            verdict_next = outcome_next;
        else if (!term_found_next)
            verdict_next = hrlv_pkg::VERDICT_BAD_REQUEST;
        else
            verdict_next = hrlv_pkg::VERDICT_OK;
    end

    // Input register: loads whenever it is not held by a blocked final byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            in_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!req_stall)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    // Scanner state: returns to its reset value after every final byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_header_reg  <= 1'b0;
            cr_pending_reg <= 1'b0;
            line_reg       <= hrlv_pkg::LINE_RESET;
            outcome_reg    <= hrlv_pkg::VERDICT_OK;
            term_prog_reg  <= 2'd0;
            term_found_reg <= 1'b0;
            count_reg      <= '0;
        end
        else if (advance)
        begin
            if (last_reg)
            begin
                in_header_reg  <= 1'b0;
                cr_pending_reg <= 1'b0;
                line_reg       <= hrlv_pkg::LINE_RESET;
                outcome_reg    <= hrlv_pkg::VERDICT_OK;
                term_prog_reg  <= 2'd0;
                term_found_reg <= 1'b0;
                count_reg      <= '0;
            end
            else
            begin
                in_header_reg  <= in_header_next;
                cr_pending_reg <= cr_pending_next;
                line_reg       <= line_next;
                outcome_reg    <= outcome_next;
                term_prog_reg  <= term_prog_next;
                term_found_reg <= term_found_next;
                count_reg      <= count_next;
            end
        end
    end

    // Verdict register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            verdict_valid_reg <= 1'b0;
        end
        else if (advance && last_reg)
        begin
            verdict_valid_reg <= 1'b1;
        end
        else if (!verdict_stall)
        begin
            verdict_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
            verdict_reg <= verdict_next;
    end

    assign verdict_valid = verdict_valid_reg;
    assign verdict       = verdict_reg;

    // The header search never runs while the request line is still open.
    a_no_header_search_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        !in_header_reg |-> (!term_found_reg && term_prog_reg == 2'd0))
        else $error("terminator search active before the request line closed");

    // Version bytes are only counted after the second space.
    a_version_after_spaces: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg.version_length != 4'd0 |-> line_reg.spaces_seen == 2'd2)
        else $error("version bytes counted before the second space");

    // A processed final byte leaves the scanner in its reset state.
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_reg) |=> (count_reg == '0 && !in_header_reg && !cr_pending_reg))
        else $error("scanner state not cleared after a final byte");

    // A final byte is never dropped while an earlier verdict is still held.
    a_final_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && last_reg && verdict_valid_reg && verdict_stall)
        |=> (in_valid_reg && last_reg))
        else $error("final byte lost while the verdict was stalled");

endmodule

`default_nettype wire
